[rtl/smr_pkg.sv]
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types, constants and helpers for the square matrix rotator.
// ----------------------------------------------------------------------------
package smr_pkg;

   localparam int MAX_DIM     = 8;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = IDX_W + 1;
   localparam int DIM_IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SIZE_W      = 4;
   localparam int ELEM_W      = 32;
   localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
   localparam int RAM_AW      = IDX_W + 1;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = SIZE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION   = 1'd1;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_ACW = 1'b1;

   // at most two matrices in flight, one per store bank
   localparam int            JOBS_W   = 2;
   localparam logic [JOBS_W-1:0] JOBS_MAX = 2'd2;

   localparam int JQ_DEPTH = 2;
   localparam int JQ_PW    = 1;
   localparam int JQ_CW    = 2;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PW    = 2;
   localparam int OQ_CW    = 3;

   typedef struct packed {
      logic              bank;
      logic [SIZE_W-1:0] side;
      logic              dir;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [ELEM_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic busy;
      logic bank;
   } back_stat_type;

   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              last;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   // size 0 counts as 1, anything above MAX_DIM saturates
   function automatic logic [SIZE_W-1:0] side_length(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = size;
      if (n == '0) begin
         n = SIZE_W'(1);
      end
      if (n > SIZE_W'(MAX_DIM)) begin
         n = SIZE_W'(MAX_DIM);
      end
      return n;
   endfunction

endpackage

[rtl/square_matrix_rotate_90.sv]
// ----------------------------------------------------------------------------
// square_matrix_rotate_90
// Loads an n-by-n matrix row by row and emits it rotated by 90 degrees.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while loading and full is low. Once the
// n*n-th element is in, the rotated matrix comes out in row-major order, one
// item per cycle while pop is held. With the back end idle, the first item
// reaches the result ports via job handoff, store read and result queue. The
// final item is flagged by rsp_last_of_matrix. The store has two banks, so
// the next matrix loads while the previous one drains; full rises only when
// both banks hold matrices not yet fully popped. Throughput is one item in
// and one out per cycle under the same conditions, set by the store's single
// write and single read port, with an output gap between back-to-back
// matrices while the back end takes the next job. Any write of matrix_size
// restarts the current load; direction is taken when a load completes. The
// user writes configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module square_matrix_rotate_90 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [31:0]             req_element_value,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [31:0]             rsp_rotated_value,
   output logic                           rsp_last_of_matrix,
   input  logic                           csr_wr_en,
   input  logic [smr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smr_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import smr_pkg::*;

   ram_wr_type        ram_wr;
   job_type           push_job, head_job;
   logic              job_push, job_full, job_valid, job_pop, job_done;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [ELEM_W-1:0] rd_data;
   logic [ELEM_W-1:0] rsp_value;
   back_stat_type     bk_stat;

   smr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .element_value (req_element_value),
      .full          (full),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .ram_wr        (ram_wr),
      .job_push      (job_push),
      .job           (push_job),
      .job_full      (job_full),
      .job_done      (job_done)
   );

   smr_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .q_full   (job_full),
      .pop      (job_pop),
      .q_valid  (job_valid),
      .head_job (head_job)
   );

   smr_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (head_job),
      .job_pop        (job_pop),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .empty          (empty),
      .pop            (pop),
      .rotated_value  (rsp_value),
      .last_of_matrix (rsp_last_of_matrix),
      .job_done       (job_done),
      .stat           (bk_stat)
   );

   assign rsp_rotated_value = $signed(rsp_value);

   // a finished load never finds the job queue full
   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job pushed into full queue");

   // the front end never writes the bank the back end is reading
   a_bank_separate: assert property (@(posedge clock) disable iff (reset)
      (ram_wr.en && bk_stat.busy) |-> (ram_wr.addr[RAM_AW-1] != bk_stat.bank))
      else $error("load overwrites bank being emitted");

   // store reads only happen while a job is running
   a_read_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> bk_stat.busy)
      else $error("store read outside a job");

   // nothing to pop right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result queue not empty after reset");

endmodule

[rtl/smr_ram.sv]
// ----------------------------------------------------------------------------
// smr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/smr_front.sv]
// ----------------------------------------------------------------------------
// smr_front
// Load side: holds the config registers, writes incoming elements into the
// current store bank and hands a job to the back end when a matrix is full.
// ----------------------------------------------------------------------------
module smr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [smr_pkg::ELEM_W-1:0]      element_value,
   output logic                            full,
   input  logic                            csr_wr_en,
   input  logic [smr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [smr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output smr_pkg::ram_wr_type             ram_wr,
   output logic                            job_push,
   output smr_pkg::job_type                job,
   input  logic                            job_full,
   input  logic                            job_done
);
   import smr_pkg::*;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic              dir_ff, dir_in;
   logic [IDX_W-1:0]  load_cnt_ff, load_cnt_in;
   logic              bank_ff, bank_in;
   logic [JOBS_W-1:0] jobs_ff, jobs_in;

   logic [SIZE_W-1:0] side;
   logic [CNT_W-1:0]  total;
   logic              accept;
   logic              last_elem;

   always_comb begin
      side      = side_length(size_ff);
      total     = CNT_W'(side) * CNT_W'(side);
      full      = (jobs_ff == JOBS_MAX) || job_full;
      accept    = push && !full;
      last_elem = (CNT_W'(load_cnt_ff) + CNT_W'(1)) == total;
      job_push  = accept && last_elem;
      job.bank  = bank_ff;
      job.side  = side;
      job.dir   = dir_ff;

      ram_wr.en   = accept;
      ram_wr.addr = {bank_ff, load_cnt_ff};
      ram_wr.data = element_value;
   end

   always_comb begin
      size_in     = size_ff;
      dir_in      = dir_ff;
      load_cnt_in = load_cnt_ff;
      bank_in     = bank_ff;
      jobs_in     = jobs_ff + JOBS_W'(job_push) - JOBS_W'(job_done);
      if (accept) begin
         if (last_elem) begin
            load_cnt_in = '0;
            bank_in     = !bank_ff;
         end else begin
            load_cnt_in = load_cnt_ff + IDX_W'(1);
         end
      end
      // a size change restarts the load
      if (csr_wr_en && csr_index == CSR_MATRIX_SIZE) begin
         size_in     = csr_wr_data[SIZE_W-1:0];
         load_cnt_in = '0;
      end
      if (csr_wr_en && csr_index == CSR_DIRECTION) begin
         dir_in = csr_wr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_W'(MAX_DIM);
         dir_ff      <= DIR_CW;
         load_cnt_ff <= '0;
         bank_ff     <= 1'b0;
         jobs_ff     <= '0;
      end else begin
         size_ff     <= size_in;
         dir_ff      <= dir_in;
         load_cnt_ff <= load_cnt_in;
         bank_ff     <= bank_in;
         jobs_ff     <= jobs_in;
      end
   end

endmodule

[rtl/smr_job_queue.sv]
// ----------------------------------------------------------------------------
// smr_job_queue
// Two-entry queue of finished-load descriptors between front and back end.
// ----------------------------------------------------------------------------
module smr_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  smr_pkg::job_type push_job,
   output logic             q_full,
   input  logic             pop,
   output logic             q_valid,
   output smr_pkg::job_type head_job
);
   import smr_pkg::*;

   job_type           mem_ff [JQ_DEPTH];
   logic [JQ_PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [JQ_PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [JQ_CW-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      q_full    = cnt_ff == JQ_CW'(JQ_DEPTH);
      q_valid   = cnt_ff != '0;
      head_job  = mem_ff[rd_ptr_ff];
      do_push   = push && !q_full;
      do_pop    = pop && q_valid;
      wr_ptr_in = wr_ptr_ff + JQ_PW'(do_push);
      rd_ptr_in = rd_ptr_ff + JQ_PW'(do_pop);
      cnt_in    = cnt_ff + JQ_CW'(do_push) - JQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[rtl/smr_back.sv]
// ----------------------------------------------------------------------------
// smr_back
// Emit side: walks the store in rotated order, one read per cycle while the
// small result queue has room, and collects the read data in that queue.
// ----------------------------------------------------------------------------
module smr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  smr_pkg::job_type            job,
   output logic                        job_pop,
   output logic                        rd_en,
   output logic [smr_pkg::RAM_AW-1:0]  rd_addr,
   input  logic [smr_pkg::ELEM_W-1:0]  rd_data,
   output logic                        empty,
   input  logic                        pop,
   output logic [smr_pkg::ELEM_W-1:0]  rotated_value,
   output logic                        last_of_matrix,
   output logic                        job_done,
   output smr_pkg::back_stat_type      stat
);
   import smr_pkg::*;

   back_state_type    state_ff, state_in;

   logic [SIZE_W-1:0] side_ff;
   logic              dir_ff;
   logic              bank_ff;
   logic [DIM_IW-1:0] row_ff, col_ff;
   logic [IDX_W-1:0]  src_ff, row_src_ff;

   logic              rd_vld_ff, rd_last_ff;

   rsp_type           oq_ff [OQ_DEPTH];
   logic [OQ_PW-1:0]  oq_wr_ff, oq_rd_ff;
   logic [OQ_CW-1:0]  oq_cnt_ff;

   logic [SIZE_W-1:0] side_m1;
   logic              row_end, col_end;
   logic              credit, issue, issue_last;
   logic [CNT_W-1:0]  nn;
   logic [IDX_W-1:0]  step, next_row_src;
   logic              oq_push, oq_pop;
   rsp_type           head;

   always_comb begin
      side_m1 = side_ff - SIZE_W'(1);
      col_end = col_ff == side_m1[DIM_IW-1:0];
      row_end = row_ff == side_m1[DIM_IW-1:0];
      credit  = (oq_cnt_ff + OQ_CW'(rd_vld_ff)) < OQ_CW'(OQ_DEPTH);
      step    = IDX_W'(side_ff);
      nn      = CNT_W'(job.side) * CNT_W'(job.side);
      next_row_src = (dir_ff == DIR_CW) ? row_src_ff + IDX_W'(1)
                                        : row_src_ff - IDX_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (credit && row_end && col_end) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop    = 1'b0;
      issue      = 1'b0;
      issue_last = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_pop = job_valid;
         end
         BK_RUN: begin
            issue      = credit;
            issue_last = credit && row_end && col_end;
         end
         default: ;
      endcase
   end

   assign rd_en   = issue;
   assign rd_addr = {bank_ff, src_ff};

   // clockwise: start at bottom of a column and walk up; anticlockwise:
   // start at top of the mirrored column and walk down
   always_ff @(posedge clock) begin
      if (job_pop) begin
         side_ff <= job.side;
         dir_ff  <= job.dir;
         bank_ff <= job.bank;
         row_ff  <= '0;
         col_ff  <= '0;
         if (job.dir == DIR_CW) begin
            src_ff     <= IDX_W'(nn - CNT_W'(job.side));
            row_src_ff <= IDX_W'(nn - CNT_W'(job.side));
         end else begin
            src_ff     <= IDX_W'(job.side - SIZE_W'(1));
            row_src_ff <= IDX_W'(job.side - SIZE_W'(1));
         end
      end else if (issue) begin
         if (col_end) begin
            col_ff     <= '0;
            row_ff     <= row_ff + DIM_IW'(1);
            row_src_ff <= next_row_src;
            src_ff     <= next_row_src;
         end else begin
            col_ff <= col_ff + DIM_IW'(1);
            src_ff <= (dir_ff == DIR_CW) ? src_ff - step : src_ff + step;
         end
      end
   end

   // result queue
   always_comb begin
      oq_push        = rd_vld_ff;
      empty          = oq_cnt_ff == '0;
      oq_pop         = pop && !empty;
      head           = oq_ff[oq_rd_ff];
      rotated_value  = head.value;
      last_of_matrix = head.last;
      job_done       = oq_pop && head.last;
      stat.busy      = state_ff == BK_RUN;
      stat.bank      = bank_ff;
   end

   always_ff @(posedge clock) begin
      rd_last_ff <= issue_last;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= '{value: rd_data, last: rd_last_ff};
      end
      if (reset) begin
         state_ff  <= BK_IDLE;
         rd_vld_ff <= 1'b0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         oq_wr_ff  <= oq_wr_ff + OQ_PW'(oq_push);
         oq_rd_ff  <= oq_rd_ff + OQ_PW'(oq_pop);
         oq_cnt_ff <= oq_cnt_ff + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
      end
   end

endmodule
